// ===== hw/rtl/gpt_pkg.sv =====
// Shared types, codes and constants of the gate position tracker.
package gpt_pkg;

    // Fixed-point scale: percents are unsigned Q7.8, so 100 percent is 25600.
    localparam int unsigned PCT_W      = 15;
    localparam logic [PCT_W-1:0] FULL_Q8       = 15'd25600;
    localparam logic [PCT_W-1:0] OPEN_OFS_MAX  = 15'd25344;
    localparam logic [PCT_W-1:0] CLOSE_OFS_MIN = 15'd256;

    // Restoring divider: one quotient bit per step.
    localparam int unsigned DIV_STEPS = PCT_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned PROD_W    = 2 * PCT_W;

    localparam logic [7:0] PHOTOCELL_CODE = 8'h62;

    // Item modes.
    localparam logic [2:0] MODE_STATUS   = 3'd0;
    localparam logic [2:0] MODE_REPORT   = 3'd1;
    localparam logic [2:0] MODE_STOP     = 3'd2;
    localparam logic [2:0] MODE_STOP_ACK = 3'd3;
    localparam logic [2:0] MODE_MOVE     = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPENING_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSING_OFFSET = 3'd3;

    typedef enum logic [3:0] {
        MOT_UNKNOWN     = 4'd0,
        MOT_OPENING     = 4'd1,
        MOT_OPENED      = 4'd2,
        MOT_CLOSING     = 4'd3,
        MOT_AUTOCLOSING = 4'd4,
        MOT_CLOSED      = 4'd5,
        MOT_STOPPED     = 4'd6,
        MOT_PEDOPENING  = 4'd7,
        MOT_PEDOPENED   = 4'd8
    } gpt_motion_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_DIV,
        SEQ_DONE
    } gpt_seq_t;

    typedef enum logic [1:0] {
        OP_MOTOR1,
        OP_MOTOR2,
        OP_GATE
    } gpt_op_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] status_byte;
        logic [7:0] motor1_raw;
        logic [7:0] motor1_speed;
        logic [7:0] motor1_load;
        logic [7:0] motor2_raw;
        logic [7:0] motor2_speed;
        logic [7:0] motor2_load;
        logic [3:0] state_code;
    } gpt_item_t;

    typedef struct packed {
        logic [PCT_W-1:0] motor1_percent;
        logic [PCT_W-1:0] motor2_percent;
        logic [PCT_W-1:0] gate_percent;
        logic [3:0]       motion;
        logic             moving;
        logic             manual_stop_flag;
        logic             obstruction_flag;
        logic             photocell;
        logic [7:0]       speed1_out;
        logic [7:0]       load1_out;
        logic [7:0]       speed2_out;
        logic [7:0]       load2_out;
    } gpt_result_t;

endpackage

// ===== hw/rtl/gate_position_tracker.sv =====
// Top level of the gate position tracker: item decode, state and a shared divider sequencer.
//
// The tracker takes one item at a time and answers every accepted item with exactly one
// result item. An item is taken only while the sequencer is idle; a finished result waits in
// the output register, and the next item may already be accepted while it waits. The three
// percents (motor 1, motor 2, gate) are worked out in turn. Each percent has a set-up step
// that selects its operands and settles the trivial cases by a compare (at or below the
// closed end, at or beyond the open end, or no correction to apply). A percent that really
// needs a division then goes through one shared restoring divider that retires one quotient
// bit per cycle. Once the gate percent is done, the output register is loaded as soon as the
// previous result has been taken or none waits there. The next item can be accepted only
// after that load, so the block does not take a new item before it is through with the last
// one. Configuration writes take effect at once and should only be made while the block is
// idle with no result outstanding.
module gate_position_tracker
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           item_valid,
    output logic                           item_ready,
    input  gpt_pkg::gpt_item_t             item,

    output logic                           result_valid,
    input  logic                           result_ready,
    output gpt_pkg::gpt_result_t           result,

    input  logic                           cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpt_pkg::PCT_W-1:0]      cfg_data
);
    import gpt_pkg::*;

    // Configuration registers.
    logic [7:0]       fb_min_reg;
    logic [7:0]       fb_max_reg;
    logic [PCT_W-1:0] open_ofs_reg;
    logic [PCT_W-1:0] close_ofs_reg;

    // Tracked state of the gate.
    gpt_motion_t motion_reg,     motion_next;
    logic [7:0]  raw1_reg,       raw1_next;
    logic [7:0]  raw2_reg,       raw2_next;
    logic [7:0]  closed1_reg,    closed1_next;
    logic [7:0]  closed2_reg,    closed2_next;
    logic [7:0]  open1_reg,      open1_next;
    logic [7:0]  open2_reg,      open2_next;
    logic [3:0]  ref_valid_reg,  ref_valid_next;
    logic [7:0]  speed1_reg,     speed1_next;
    logic [7:0]  load1_reg,      load1_next;
    logic [7:0]  speed2_reg,     speed2_next;
    logic [7:0]  load2_reg,      load2_next;
    logic        pending_reg,    pending_next;
    logic        acked_reg,      acked_next;
    logic        manual_reg,     manual_next;
    logic        obstruct_reg,   obstruct_next;
    logic        photocell_reg,  photocell_next;

    // Sequencer and divider.
    gpt_seq_t          seq_reg,   seq_next;
    gpt_op_t           op_reg,    op_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [PCT_W-1:0]  rem_reg,   rem_next;
    logic [PCT_W-1:0]  quo_reg,   quo_next;
    logic [PCT_W-1:0]  den_reg,   den_next;
    logic [PCT_W-1:0]  m1_reg;
    logic [PCT_W-1:0]  m2_reg;
    logic [PCT_W-1:0]  gate_reg;

    // Output register.
    logic              res_valid_reg, res_valid_next;
    gpt_result_t       result_reg;

    logic              item_accept;
    logic              res_load;

    // Operand selection for the current percent.
    logic [7:0]        mot_raw;
    logic [7:0]        mot_lo;
    logic [7:0]        mot_hi;
    logic              mot_learned;
    logic [PCT_W:0]    m_sum;
    logic [PCT_W-1:0]  gate_base;
    logic              op_zero;
    logic              op_full;
    logic              op_pass;
    logic [PCT_W-1:0]  op_num;
    logic [PCT_W-1:0]  op_den;
    logic [PROD_W-1:0] num_wide;
    logic [PROD_W-1:0] dividend;

    // One divider step.
    logic [PCT_W:0]    trial;
    logic [PCT_W:0]    trial_diff;
    logic              trial_ge;

    // Result write-back of the current percent.
    logic              res_we;
    logic [PCT_W-1:0]  res_val;

    logic              moving;

    assign item_accept = item_valid && item_ready;
    assign item_ready  = (seq_reg == SEQ_IDLE);

    //------------------------------------------------------------------------
    // Configuration port. Offsets are clamped when they are written, so the
    // datapath never sees an opening offset above 99 percent or a closing
    // offset outside 1 to 100 percent.
    //------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_min_reg    <= 8'd0;
            fb_max_reg    <= 8'd255;
            open_ofs_reg  <= '0;
            close_ofs_reg <= FULL_Q8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FALLBACK_MIN:   fb_min_reg <= cfg_data[7:0];
                REG_FALLBACK_MAX:   fb_max_reg <= cfg_data[7:0];
                REG_OPENING_OFFSET: open_ofs_reg <=
                    (cfg_data > OPEN_OFS_MAX) ? OPEN_OFS_MAX : cfg_data;
                REG_CLOSING_OFFSET:
                begin
                    if (cfg_data < CLOSE_OFS_MIN)
                        close_ofs_reg <= CLOSE_OFS_MIN;
                    else if (cfg_data > FULL_Q8)
                        close_ofs_reg <= FULL_Q8;
                    else
                        close_ofs_reg <= cfg_data;
                end
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------------
    // Item decode: the state of the gate changes on the edge that accepts the
    // item; the percents are then worked out from the new state.
    //------------------------------------------------------------------------
    always_comb
    begin
        motion_next    = motion_reg;
        raw1_next      = raw1_reg;
        raw2_next      = raw2_reg;
        closed1_next   = closed1_reg;
        closed2_next   = closed2_reg;
        open1_next     = open1_reg;
        open2_next     = open2_reg;
        ref_valid_next = ref_valid_reg;
        speed1_next    = speed1_reg;
        load1_next     = load1_reg;
        speed2_next    = speed2_reg;
        load2_next     = load2_reg;
        pending_next   = pending_reg;
        acked_next     = acked_reg;
        manual_next    = manual_reg;
        obstruct_next  = obstruct_reg;
        photocell_next = photocell_reg;

        if (item_accept)
        begin
            case (item.mode)
                MODE_STATUS:
                begin
                    photocell_next = (item.status_byte == PHOTOCELL_CODE);
                    raw1_next      = item.motor1_raw;
                    speed1_next    = item.motor1_speed;
                    load1_next     = item.motor1_load;
                    raw2_next      = item.motor2_raw;
                    speed2_next    = item.motor2_speed;
                    load2_next     = item.motor2_load;
                end
                MODE_REPORT:
                begin
                    // Endpoints are learned from the raw positions at hand.
                    if (item.state_code == MOT_CLOSED)
                    begin
                        closed1_next   = raw1_reg;
                        closed2_next   = raw2_reg;
                        ref_valid_next = ref_valid_reg | 4'b0011;
                    end
                    else if (item.state_code == MOT_OPENED)
                    begin
                        open1_next     = raw1_reg;
                        open2_next     = raw2_reg;
                        ref_valid_next = ref_valid_reg | 4'b1100;
                    end
                    else if (item.state_code == MOT_PEDOPENED)
                    begin
                        open1_next     = raw1_reg;
                        ref_valid_next = ref_valid_reg | 4'b0100;
                    end

                    // A stop counts as manual only if it was sent and acknowledged;
                    // the stop context itself is kept.
                    if (item.state_code == MOT_STOPPED)
                    begin
                        motion_next   = MOT_STOPPED;
                        manual_next   = pending_reg && acked_reg;
                        obstruct_next = !(pending_reg && acked_reg);
                    end
                    else if (item.state_code inside {[MOT_OPENING:MOT_PEDOPENED]})
                    begin
                        pending_next  = 1'b0;
                        acked_next    = 1'b0;
                        manual_next   = 1'b0;
                        obstruct_next = 1'b0;
                        motion_next   = gpt_motion_t'(item.state_code);
                    end
                end
                MODE_STOP:
                begin
                    pending_next = 1'b1;
                    acked_next   = 1'b0;
                    manual_next  = 1'b0;
                end
                MODE_STOP_ACK:
                begin
                    acked_next = 1'b1;
                end
                MODE_MOVE:
                begin
                    // The obstruction flag survives a new move command.
                    pending_next = 1'b0;
                    acked_next   = 1'b0;
                    manual_next  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------------
    // Operand selection. Every percent has the form 25600 * num / den with a
    // saturation at 25600, so a compare settles the trivial cases and the
    // divider only ever sees num < den, which keeps the quotient in 15 bits.
    //------------------------------------------------------------------------
    always_comb
    begin
        if (op_reg == OP_MOTOR1)
        begin
            mot_raw     = raw1_reg;
            mot_learned = ref_valid_reg[0] && ref_valid_reg[2] && (open1_reg > closed1_reg);
            mot_lo      = mot_learned ? closed1_reg : fb_min_reg;
            mot_hi      = mot_learned ? open1_reg   : fb_max_reg;
        end
        else
        begin
            mot_raw     = raw2_reg;
            mot_learned = ref_valid_reg[1] && ref_valid_reg[3] && (open2_reg > closed2_reg);
            mot_lo      = mot_learned ? closed2_reg : fb_min_reg;
            mot_hi      = mot_learned ? open2_reg   : fb_max_reg;
        end
    end

    assign m_sum = {1'b0, m1_reg} + {1'b0, m2_reg};

    // Pedestrian states follow motor 1 alone; otherwise both leaves are averaged.
    assign gate_base = ((motion_reg == MOT_PEDOPENING) || (motion_reg == MOT_PEDOPENED))
                     ? m1_reg : m_sum[PCT_W:1];

    always_comb
    begin
        op_zero = 1'b0;
        op_full = 1'b0;
        op_pass = 1'b0;
        op_num  = '0;
        op_den  = FULL_Q8;

        if (op_reg == OP_GATE)
        begin
            if (((motion_reg == MOT_OPENING) || (motion_reg == MOT_PEDOPENING))
                && (open_ofs_reg < OPEN_OFS_MAX))
            begin
                // Stretch the range above the opening start offset to 0..100.
                op_num  = gate_base - open_ofs_reg;
                op_den  = FULL_Q8 - open_ofs_reg;
                op_zero = (gate_base <= open_ofs_reg);
                op_full = !op_zero && (op_num >= op_den);
            end
            else if (motion_reg == MOT_CLOSING)
            begin
                // Stretch the range below the closing start offset to 0..100.
                op_num  = gate_base;
                op_den  = close_ofs_reg;
                op_full = (gate_base >= close_ofs_reg);
            end
            else
            begin
                op_pass = 1'b1;
            end
        end
        else
        begin
            op_num  = {{(PCT_W-8){1'b0}}, mot_raw - mot_lo};
            op_den  = {{(PCT_W-8){1'b0}}, mot_hi - mot_lo};
            op_zero = (mot_hi <= mot_lo) || (mot_raw <= mot_lo);
            op_full = !op_zero && (op_num >= op_den);
        end
    end

    // 25600 = 2^14 + 2^13 + 2^10, so the scaling is two adds.
    assign num_wide = {{(PROD_W-PCT_W){1'b0}}, op_num};
    assign dividend = (num_wide << 14) + (num_wide << 13) + (num_wide << 10);

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial      = {rem_reg, quo_reg[PCT_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});

    //------------------------------------------------------------------------
    // Sequencer: motor 1, motor 2 and the gate percent, in that order.
    //------------------------------------------------------------------------
    always_comb
    begin
        seq_next = seq_reg;
        op_next  = op_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        res_we   = 1'b0;
        res_val  = '0;
        res_load = 1'b0;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (item_accept)
                begin
                    seq_next = SEQ_LOAD;
                    op_next  = OP_MOTOR1;
                end
            end
            SEQ_LOAD:
            begin
                if (op_zero || op_full || op_pass)
                begin
                    res_we  = 1'b1;
                    res_val = op_zero ? '0 : (op_full ? FULL_Q8 : gate_base);
                end
                else
                begin
                    // num < den guarantees the upper half is already below den.
                    rem_next = dividend[PROD_W-1:PCT_W];
                    quo_next = dividend[PCT_W-1:0];
                    den_next = op_den;
                    cnt_next = '0;
                    seq_next = SEQ_DIV;
                end
            end
            SEQ_DIV:
            begin
                rem_next = trial_ge ? trial_diff[PCT_W-1:0] : trial[PCT_W-1:0];
                quo_next = {quo_reg[PCT_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    res_we  = 1'b1;
                    res_val = {quo_reg[PCT_W-2:0], trial_ge};
                end
            end
            SEQ_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_load = 1'b1;
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase

        // A finished percent moves the sequencer on to the next one.
        if (res_we)
        begin
            if (op_reg == OP_GATE)
            begin
                seq_next = SEQ_DONE;
            end
            else
            begin
                seq_next = SEQ_LOAD;
                op_next  = (op_reg == OP_MOTOR1) ? OP_MOTOR2 : OP_GATE;
            end
        end

        if (res_load)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    assign moving = (motion_reg inside {MOT_OPENING, MOT_CLOSING,
                                        MOT_PEDOPENING, MOT_AUTOCLOSING});

    //------------------------------------------------------------------------
    // Registers.
    //------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg    <= MOT_UNKNOWN;
            raw1_reg      <= '0;
            raw2_reg      <= '0;
            closed1_reg   <= '0;
            closed2_reg   <= '0;
            open1_reg     <= '0;
            open2_reg     <= '0;
            ref_valid_reg <= '0;
            speed1_reg    <= '0;
            load1_reg     <= '0;
            speed2_reg    <= '0;
            load2_reg     <= '0;
            pending_reg   <= 1'b0;
            acked_reg     <= 1'b0;
            manual_reg    <= 1'b0;
            obstruct_reg  <= 1'b0;
            photocell_reg <= 1'b0;
            seq_reg       <= SEQ_IDLE;
            op_reg        <= OP_MOTOR1;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            motion_reg    <= motion_next;
            raw1_reg      <= raw1_next;
            raw2_reg      <= raw2_next;
            closed1_reg   <= closed1_next;
            closed2_reg   <= closed2_next;
            open1_reg     <= open1_next;
            open2_reg     <= open2_next;
            ref_valid_reg <= ref_valid_next;
            speed1_reg    <= speed1_next;
            load1_reg     <= load1_next;
            speed2_reg    <= speed2_next;
            load2_reg     <= load2_next;
            pending_reg   <= pending_next;
            acked_reg     <= acked_next;
            manual_reg    <= manual_next;
            obstruct_reg  <= obstruct_next;
            photocell_reg <= photocell_next;
            seq_reg       <= seq_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;

        if (res_we)
        begin
            case (op_reg)
                OP_MOTOR1: m1_reg   <= res_val;
                OP_MOTOR2: m2_reg   <= res_val;
                OP_GATE:   gate_reg <= res_val;
                default:   gate_reg <= res_val;
            endcase
        end

        if (res_load)
        begin
            result_reg.motor1_percent   <= m1_reg;
            result_reg.motor2_percent   <= m2_reg;
            result_reg.gate_percent     <= gate_reg;
            result_reg.motion           <= motion_reg;
            result_reg.moving           <= moving;
            result_reg.manual_stop_flag <= manual_reg;
            result_reg.obstruction_flag <= obstruct_reg;
            result_reg.photocell        <= photocell_reg;
            result_reg.speed1_out       <= speed1_reg;
            result_reg.load1_out        <= load1_reg;
            result_reg.speed2_out       <= speed2_reg;
            result_reg.load2_out        <= load2_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/gpt_checker.sv =====
// Port-level checks of the gate position tracker and their binding to the top level.
module gpt_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input gpt_pkg::gpt_result_t           result
);
    import gpt_pkg::*;

    // A result that is not taken stays and does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while the previous one is still being worked");

    // Every percent is saturated at 100.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.motor1_percent <= FULL_Q8)
                      && (result.motor2_percent <= FULL_Q8)
                      && (result.gate_percent <= FULL_Q8))
        else $error("percent above 100");

    // The moving flag matches the reported motion.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.moving == ((result.motion == MOT_OPENING)
                                        || (result.motion == MOT_CLOSING)
                                        || (result.motion == MOT_PEDOPENING)
                                        || (result.motion == MOT_AUTOCLOSING)))
        else $error("moving flag disagrees with motion");

    // A stop is classified as manual or as an obstruction, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.manual_stop_flag && result.obstruction_flag))
        else $error("stop classified both ways");

endmodule

bind gate_position_tracker gpt_checker u_gpt_checker (.*);

// ===== tb/gpt_position_checker.sv =====
// Checker for the gate position tracker: predicts each result item and compares it field by field.
module gpt_position_checker
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    input  logic                          item_ready,
    input  gpt_pkg::gpt_item_t            item,

    input  logic                          result_valid,
    input  logic                          result_ready,
    input  gpt_pkg::gpt_result_t          result,

    input  logic                          cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpt_pkg::PCT_W-1:0]     cfg_data,

    output int unsigned                   mismatches,
    output int unsigned                   awaited,
    output int unsigned                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gpt_pkg::*;

    // Endpoint-learned bits: motor 1 and 2 closed in the low pair, open in the high pair.
    localparam logic [3:0] LEARN_CLOSED_BOTH = 4'b0011;
    localparam logic [3:0] LEARN_OPEN_BOTH   = 4'b1100;
    localparam logic [3:0] LEARN_OPEN_M1     = 4'b0100;

    // Shadow of the configuration registers.
    logic [7:0]       fb_min;
    logic [7:0]       fb_max;
    logic [PCT_W-1:0] open_ofs;
    logic [PCT_W-1:0] close_ofs;

    // Shadow of the tracker state.
    gpt_motion_t      motion_q;
    logic [1:0][7:0]  pos;
    logic [1:0][7:0]  end_closed;
    logic [1:0][7:0]  end_open;
    logic [3:0]       learned;
    logic [3:0][7:0]  latch;
    logic             stop_sent;
    logic             stop_acked_q;
    logic             manual_q;
    logic             obstruct_q;
    logic             pcell_q;

    gpt_result_t      predicted_positions[$];

    // Scale a raw position between two ends into a Q7.8 percent.
    function automatic int unsigned span_pct(int unsigned raw, int unsigned lo, int unsigned hi);
        int unsigned v;
        if (hi <= lo || raw <= lo)
            return 0;
        v = (32'(FULL_Q8) * (raw - lo)) / (hi - lo);
        return (v > FULL_Q8) ? 32'(FULL_Q8) : v;
    endfunction

    // Learned endpoints win only when both are known and in the right order.
    function automatic logic [PCT_W-1:0] motor_pct(int m);
        if (learned[m] && learned[m+2] && end_open[m] > end_closed[m])
            return PCT_W'(span_pct(pos[m], end_closed[m], end_open[m]));
        return PCT_W'(span_pct(pos[m], fb_min, fb_max));
    endfunction

    function automatic string field_diff(string name, logic [PCT_W-1:0] want_v,
                                         logic [PCT_W-1:0] got_v);
        return (got_v !== want_v) ? $sformatf(" %s exp %0d got %0d", name, want_v, got_v) : "";
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        gpt_result_t      want;
        string            diffs;
        logic [PCT_W-1:0] m1;
        logic [PCT_W-1:0] m2;
        int unsigned      base;
        int unsigned      gate;
        if (!rst_n) begin
            fb_min       = 8'd0;
            fb_max       = 8'd255;
            open_ofs     = '0;
            close_ofs    = FULL_Q8;
            motion_q     = MOT_UNKNOWN;
            pos          = '0;
            end_closed   = '0;
            end_open     = '0;
            learned      = '0;
            latch        = '0;
            stop_sent    = 1'b0;
            stop_acked_q = 1'b0;
            manual_q     = 1'b0;
            obstruct_q   = 1'b0;
            pcell_q      = 1'b0;
            predicted_positions.delete();
            mismatches   = 0;
            checked      = 0;
            awaited      = 0;
        end else begin
            // A result leaving this edge always belongs to an earlier item.
            if (result_valid && result_ready) begin
                checked++;
                if (predicted_positions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: result with no item outstanding: %p", result);
                end else begin
                    want  = predicted_positions.pop_front();
                    diffs = {field_diff("motor1_percent", want.motor1_percent,
                                        result.motor1_percent),
                             field_diff("motor2_percent", want.motor2_percent,
                                        result.motor2_percent),
                             field_diff("gate_percent", want.gate_percent, result.gate_percent),
                             field_diff("motion", want.motion, result.motion),
                             field_diff("moving", want.moving, result.moving),
                             field_diff("manual_stop_flag", want.manual_stop_flag,
                                        result.manual_stop_flag),
                             field_diff("obstruction_flag", want.obstruction_flag,
                                        result.obstruction_flag),
                             field_diff("photocell", want.photocell, result.photocell),
                             field_diff("speed1_out", want.speed1_out, result.speed1_out),
                             field_diff("load1_out", want.load1_out, result.load1_out),
                             field_diff("speed2_out", want.speed2_out, result.speed2_out),
                             field_diff("load2_out", want.load2_out, result.load2_out)};
                    if (diffs != "") begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("checker: result %0d mismatch:%s", checked, diffs);
                    end
                end
            end

            if (item_valid && item_ready) begin
                case (item.mode)
                    MODE_STATUS: begin
                        pcell_q  = (item.status_byte == PHOTOCELL_CODE);
                        pos[0]   = item.motor1_raw;
                        pos[1]   = item.motor2_raw;
                        latch[0] = item.motor1_speed;
                        latch[1] = item.motor1_load;
                        latch[2] = item.motor2_speed;
                        latch[3] = item.motor2_load;
                    end
                    MODE_REPORT: begin
                        if (item.state_code == MOT_CLOSED) begin
                            end_closed = pos;
                            learned    = learned | LEARN_CLOSED_BOTH;
                        end else if (item.state_code == MOT_OPENED) begin
                            end_open = pos;
                            learned  = learned | LEARN_OPEN_BOTH;
                        end else if (item.state_code == MOT_PEDOPENED) begin
                            end_open[0] = pos[0];
                            learned     = learned | LEARN_OPEN_M1;
                        end
                        if (item.state_code == MOT_STOPPED) begin
                            motion_q   = MOT_STOPPED;
                            manual_q   = stop_sent && stop_acked_q;
                            obstruct_q = !manual_q;
                        end else if (item.state_code >= MOT_OPENING &&
                                     item.state_code <= MOT_PEDOPENED) begin
                            stop_sent    = 1'b0;
                            stop_acked_q = 1'b0;
                            manual_q     = 1'b0;
                            obstruct_q   = 1'b0;
                            motion_q     = gpt_motion_t'(item.state_code);
                        end
                    end
                    MODE_STOP: begin
                        stop_sent    = 1'b1;
                        stop_acked_q = 1'b0;
                        manual_q     = 1'b0;
                    end
                    MODE_STOP_ACK: stop_acked_q = 1'b1;
                    MODE_MOVE: begin
                        stop_sent    = 1'b0;
                        stop_acked_q = 1'b0;
                        manual_q     = 1'b0;
                    end
                    default: ;
                endcase

                m1 = motor_pct(0);
                m2 = motor_pct(1);
                base = m1;
                if (motion_q != MOT_PEDOPENING && motion_q != MOT_PEDOPENED)
                    base = (base + m2) >> 1;

                // Start-offset correction of the gate percent.
                gate = base;
                if (motion_q == MOT_OPENING || motion_q == MOT_PEDOPENING) begin
                    if (open_ofs < OPEN_OFS_MAX)
                        gate = (base <= open_ofs) ? 0 :
                               (32'(FULL_Q8) * (base - open_ofs)) / (FULL_Q8 - open_ofs);
                end else if (motion_q == MOT_CLOSING) begin
                    gate = (32'(FULL_Q8) * base) / close_ofs;
                end
                if (gate > FULL_Q8)
                    gate = FULL_Q8;

                want.motor1_percent   = m1;
                want.motor2_percent   = m2;
                want.gate_percent     = PCT_W'(gate);
                want.motion           = motion_q;
                want.moving           = (motion_q == MOT_OPENING) || (motion_q == MOT_CLOSING) ||
                                        (motion_q == MOT_PEDOPENING) ||
                                        (motion_q == MOT_AUTOCLOSING);
                want.manual_stop_flag = manual_q;
                want.obstruction_flag = obstruct_q;
                want.photocell        = pcell_q;
                want.speed1_out       = latch[0];
                want.load1_out        = latch[1];
                want.speed2_out       = latch[2];
                want.load2_out        = latch[3];
                predicted_positions.insert(predicted_positions.size(), want);
            end

            if (cfg_we) begin
                case (cfg_index)
                    REG_FALLBACK_MIN:   fb_min   = cfg_data[7:0];
                    REG_FALLBACK_MAX:   fb_max   = cfg_data[7:0];
                    REG_OPENING_OFFSET: open_ofs = (cfg_data > OPEN_OFS_MAX) ? OPEN_OFS_MAX
                                                                             : cfg_data;
                    REG_CLOSING_OFFSET: close_ofs = (cfg_data < CLOSE_OFS_MIN) ? CLOSE_OFS_MIN :
                                                    (cfg_data > FULL_Q8) ? FULL_Q8 : cfg_data;
                    default: ;
                endcase
            end

            awaited = predicted_positions.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the gate position tracker: stimulus, flow control, phases and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpt_pkg::*;

    // Settle time after draining; it exceeds the time the block takes to answer an item when the receiver keeps up.
    localparam int SETTLE_CYCLES = 60;
    // This cycle limit leaves a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 300;
    localparam int NUM_PHASES    = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    gpt_item_t             item;
    logic                  result_valid;
    logic                  result_ready;
    gpt_result_t           result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [PCT_W-1:0]      cfg_data;

    int unsigned           mismatch_total;
    int unsigned           outstanding;
    int unsigned           results_checked;

    // Flow-control knobs shared between the sender (main process) and the receiver process.
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    bit                    hold_req      = 1'b0;
    int                    hold_len      = 0;

    // Bookkeeping for the summary and for the length of each phase.
    int                    items_sent     = 0;
    int                    useful_items   = 0;
    int                    directed_items = 0;
    int                    reg_writes     = 0;
    int                    cycles         = 0;

    // Current idea of where each motor's travel ends, used to shape realistic travel.
    int                    end_lo[2] = '{0, 0};
    int                    end_hi[2] = '{255, 255};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    gate_position_tracker u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gpt_position_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatch_total),
        .awaited      (outstanding),
        .checked      (results_checked)
    );

    // Watchdog: a hung handshake must not stall the run forever.
    initial begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk) cycles++;
        $display("tb: FAIL");
        $finish;
    end

    // Receiver side. Ready changes at the falling edge only. A hold-off request keeps ready
    // low for a counted stretch so that the block backs up and stalls its input.
    initial begin
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                result_ready = 1'b0;
                for (int i = 0; i < hold_len; i++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] clip8(int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // An item of the given mode with every other field random. The photocell code shows up
    // often enough to flip the flag both ways.
    function automatic gpt_item_t any_item(logic [2:0] mode);
        gpt_item_t it;
        it.mode         = mode;
        it.status_byte  = ($urandom_range(0, 3) == 0) ? PHOTOCELL_CODE : 8'($urandom);
        it.motor1_raw   = 8'($urandom);
        it.motor1_speed = 8'($urandom);
        it.motor1_load  = 8'($urandom);
        it.motor2_raw   = 8'($urandom);
        it.motor2_speed = 8'($urandom);
        it.motor2_load  = 8'($urandom);
        it.state_code   = 4'($urandom);
        return it;
    endfunction

    function automatic gpt_item_t frame_item(int r1, int r2);
        gpt_item_t it;
        it            = any_item(MODE_STATUS);
        it.motor1_raw = clip8(r1);
        it.motor2_raw = clip8(r2);
        return it;
    endfunction

    function automatic gpt_item_t report_item(logic [3:0] code);
        gpt_item_t it;
        it            = any_item(MODE_REPORT);
        it.state_code = code;
        return it;
    endfunction

    // Offer one item and return at the edge that accepts it. Valid stays high on return;
    // the next call or a drain decides what it does at the following falling edge.
    task automatic send_item(gpt_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        if (it.mode <= MODE_MOVE)
            useful_items++;
    endtask

    // Stop offering items and wait until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = PCT_W'(data);
        @(negedge clk);
        cfg_we    = 1'b0;
        reg_writes++;
    endtask

    // Status frames that walk both motors from one end of travel toward the other, with
    // some jitter so positions also land just outside the learned ends.
    task automatic travel(bit upward, int steps);
        int a;
        int b;
        int r[2];
        for (int k = 0; k <= steps; k++) begin
            for (int m = 0; m < 2; m++) begin
                a    = upward ? end_lo[m] : end_hi[m];
                b    = upward ? end_hi[m] : end_lo[m];
                r[m] = a + (b - a) * k / steps + int'($urandom_range(0, 8)) - 4;
            end
            send_item(frame_item(r[0], r[1]));
        end
    endtask

    // One short, mostly well-formed piece of gate life with random content.
    task automatic play_sequence();
        int         kind;
        logic [3:0] code;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                // Learn both ends. Now and then the ends come out equal or reversed,
                // which must push the tracker back onto the fallback limits.
                for (int m = 0; m < 2; m++) begin
                    end_lo[m] = $urandom_range(0, 90);
                    end_hi[m] = $urandom_range(140, 255);
                    if ($urandom_range(0, 9) == 0)
                        end_hi[m] = end_lo[m];
                    else if ($urandom_range(0, 9) == 0)
                        {end_lo[m], end_hi[m]} = {end_hi[m], end_lo[m]};
                end
                send_item(frame_item(end_lo[0], end_lo[1]));
                send_item(report_item(MOT_CLOSED));
                send_item(frame_item(end_hi[0], end_hi[1]));
                send_item(report_item(($urandom_range(0, 3) == 0) ? MOT_PEDOPENED
                                                                  : MOT_OPENED));
            end
            1, 2: begin
                if ($urandom_range(0, 1))
                    send_item(any_item(MODE_MOVE));
                code = $urandom_range(0, 2) ? MOT_OPENING : MOT_PEDOPENING;
                send_item(report_item(code));
                travel(1'b1, $urandom_range(2, 8));
                send_item(report_item((code == MOT_OPENING) ? MOT_OPENED : MOT_PEDOPENED));
            end
            3, 4: begin
                if ($urandom_range(0, 1))
                    send_item(any_item(MODE_MOVE));
                send_item(report_item($urandom_range(0, 2) ? MOT_CLOSING : MOT_AUTOCLOSING));
                travel(1'b0, $urandom_range(2, 8));
                send_item(report_item(MOT_CLOSED));
            end
            5, 6: begin
                // Commanded stop, usually acknowledged, so mostly a manual stop.
                send_item(report_item(4'($urandom_range(0, 1) ? MOT_OPENING : MOT_CLOSING)));
                travel($urandom_range(0, 1), $urandom_range(1, 4));
                send_item(any_item(MODE_STOP));
                if ($urandom_range(0, 4) != 0)
                    send_item(any_item(MODE_STOP_ACK));
                if ($urandom_range(0, 1))
                    send_item(frame_item(end_lo[0], end_hi[1]));
                send_item(report_item(MOT_STOPPED));
            end
            7: begin
                // Stop without a command: an obstruction, even after a stray acknowledge.
                send_item(report_item(4'($urandom_range(0, 1) ? MOT_PEDOPENING
                                                              : MOT_AUTOCLOSING)));
                travel($urandom_range(0, 1), $urandom_range(1, 4));
                if ($urandom_range(0, 1))
                    send_item(any_item(MODE_STOP_ACK));
                send_item(report_item(MOT_STOPPED));
                if ($urandom_range(0, 1))
                    send_item(any_item(MODE_MOVE));
            end
            8: begin
                send_item(report_item(4'($urandom)));
                send_item(any_item(3'($urandom_range(MODE_STOP, MODE_MOVE))));
            end
            default: begin
                // Noise: any mode, unused ones included, with fully random fields.
                repeat ($urandom_range(1, 3))
                    send_item(any_item(3'($urandom)));
            end
        endcase
    endtask

    initial begin
        gpt_item_t it;
        int        target;
        int        half;
        bit        pressed;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run on the reset values of the registers so those get checked too.
        // Field extremes: an all-zero frame, then an all-ones frame carrying the photocell code.
        it = '0;
        it.mode = MODE_STATUS;
        send_item(it);
        it = '1;
        it.mode = MODE_STATUS;
        it.status_byte = PHOTOCELL_CODE;
        send_item(it);
        // A status byte one off the photocell code must clear the flag.
        it = frame_item(128, 64);
        it.status_byte = PHOTOCELL_CODE + 8'd1;
        send_item(it);
        // Other and out-of-range state codes leave motion alone.
        send_item(report_item(MOT_UNKNOWN));
        send_item(report_item(4'hF));
        // Unused modes change nothing.
        for (int k = 1; k <= 3; k++)
            send_item(any_item(3'(MODE_MOVE + k)));
        // Learn closed at 128/64 and open at 200/250, then move between them.
        send_item(report_item(MOT_CLOSED));
        send_item(frame_item(200, 250));
        send_item(report_item(MOT_OPENED));
        send_item(frame_item(160, 100));
        send_item(report_item(MOT_OPENING));
        send_item(report_item(MOT_CLOSING));
        send_item(report_item(MOT_AUTOCLOSING));
        // Stop sent and acknowledged: a manual stop.
        send_item(any_item(MODE_STOP));
        send_item(any_item(MODE_STOP_ACK));
        send_item(report_item(MOT_STOPPED));
        // A move command clears the stop context: the next stop is an obstruction.
        send_item(any_item(MODE_MOVE));
        send_item(report_item(MOT_STOPPED));
        // An acknowledge with no stop pending is still an obstruction.
        send_item(any_item(MODE_STOP_ACK));
        send_item(report_item(MOT_STOPPED));
        // Pedestrian travel follows motor 1 only.
        send_item(report_item(MOT_PEDOPENING));
        send_item(frame_item(210, 90));
        send_item(report_item(MOT_PEDOPENED));
        // Below the closed end, beyond the open end, then closed learned above open.
        send_item(frame_item(0, 0));
        send_item(frame_item(255, 255));
        send_item(report_item(MOT_CLOSED));
        directed_items = items_sent;

        // Random part in phases. Each phase starts from an idle block with new register
        // values; the first three hit the extremes and the clamps, the rest are random.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_reg(REG_FALLBACK_MIN, 0);
                    write_reg(REG_FALLBACK_MAX, 255);
                    write_reg(REG_OPENING_OFFSET, 0);
                    write_reg(REG_CLOSING_OFFSET, FULL_Q8);
                end
                1: begin
                    write_reg(REG_FALLBACK_MIN, 255);
                    write_reg(REG_FALLBACK_MAX, 0);
                    write_reg(REG_OPENING_OFFSET, OPEN_OFS_MAX);
                    write_reg(REG_CLOSING_OFFSET, CLOSE_OFS_MIN);
                end
                2: begin
                    // All-ones and zero data exercise both clamps and every data bit.
                    write_reg(REG_FALLBACK_MIN, $urandom_range(0, 255));
                    write_reg(REG_FALLBACK_MAX, $urandom_range(0, 255));
                    write_reg(REG_OPENING_OFFSET, 15'h7FFF);
                    write_reg(REG_CLOSING_OFFSET, 0);
                end
                default: begin
                    write_reg(REG_FALLBACK_MIN, $urandom_range(0, 120));
                    write_reg(REG_FALLBACK_MAX, $urandom_range(100, 255));
                    write_reg(REG_OPENING_OFFSET, $urandom_range(0, 1) ?
                              $urandom_range(0, OPEN_OFS_MAX) : $urandom_range(0, 32767));
                    write_reg(REG_CLOSING_OFFSET, $urandom_range(0, 1) ?
                              $urandom_range(CLOSE_OFS_MIN, FULL_Q8) : $urandom_range(0, 32767));
                    // Writes to indexes past the last register must be ignored.
                    for (int k = 1; k <= 4; k++)
                        write_reg(CFG_IDX_W'(REG_CLOSING_OFFSET + k), $urandom_range(0, 32767));
                end
            endcase

            if (phase < 2) begin
                send_idle_pct = 30;
                recv_idle_pct = 59;
            end else if (phase < 4) begin
                send_idle_pct = 59;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            target  = useful_items + PHASE_ITEMS;
            half    = useful_items + PHASE_ITEMS / 2;
            pressed = 1'b0;
            while (useful_items < target) begin
                // Midway through, either block the receiver for a long stretch while items
                // keep coming, or let the sender pause until the block has emptied.
                if (!pressed && useful_items >= half) begin
                    pressed = 1'b1;
                    if (phase == 1 || phase == 4) begin
                        hold_len = 400;
                        hold_req = 1'b1;
                    end else begin
                        drain();
                    end
                end
                play_sequence();
            end
        end

        drain();

        $display("summary: %0d items sent (%0d directed), %0d results checked, %0d register writes",
                 items_sent, directed_items, results_checked, reg_writes);
        $display("summary: %0d phases of settings and flow control, %0d mismatches, %0d cycles",
                 NUM_PHASES, mismatch_total, cycles);
        if (mismatch_total == 0 && outstanding == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
